FILE: design/sample_std_deviation_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sample standard deviation block
// Shared forms for the concurrent checks bound to the top level.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_STD_DEVIATION_TOP_MACROS_SVH
`define SAMPLE_STD_DEVIATION_TOP_MACROS_SVH

// antecedent in this cycle, consequent in the next
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent and consequent in the same cycle
`define SSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/ssd_pkg.sv
// ----------------------------------------------------------------------------
// Sample standard deviation package
// Item types, sequencer states and control structs shared by the block.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int RMS_W    = 24;   // result width, 8 fraction bits
    localparam int ROOT_W   = 24;   // bits of the integer square root
    localparam int SCALED_W = 48;   // variance scaled by 2^16
    localparam int FRAC_W   = 16;   // scale applied before the root

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_sample;
    } t_in_item;

    typedef struct packed {
        logic [RMS_W-1:0] rms_noise;
        logic             overflowed;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEN,
        ST_MSQ,
        ST_MAG,
        ST_SUB,
        ST_DIV,
        ST_ROOT,
        ST_HOLD
    } t_calc_state;

    typedef struct packed {
        logic start;
        logic overflow;
        logic take;
    } t_calc_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_calc_sts;

endpackage

FILE: design/ssd_calc.sv
// ----------------------------------------------------------------------------
// Deviation calculator
// Sequencer around one shared add/subtract unit: shift-add products, restoring
// division and a digit-by-digit square root, then holds the result.
// ----------------------------------------------------------------------------
module ssd_calc #(
    parameter int CW = 11
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ssd_pkg::t_calc_ctl      i_ctl,
    input  logic [CW-1:0]           i_count,
    input  logic signed [CW+15:0]   i_sum,
    input  logic [CW+29:0]          i_sq_sum,
    output ssd_pkg::t_calc_sts      o_sts,
    output ssd_pkg::t_out_item      o_result
);

    localparam int SW   = CW + 16;
    localparam int MGW  = CW + 15;
    localparam int QW   = CW + 30;
    localparam int NW   = 2 * CW + 30;
    localparam int DW   = 2 * CW;
    localparam int DVW  = NW + ssd_pkg::FRAC_W;
    localparam int AW   = NW + 1;
    localparam int CNTW = $clog2(DVW);
    localparam int RW   = ssd_pkg::ROOT_W;
    localparam int QTW  = ssd_pkg::SCALED_W;

    ssd_pkg::t_calc_state r_state, n_state;

    logic [CNTW-1:0] r_cnt;
    logic [NW-1:0]   r_acc;
    logic [NW-1:0]   r_mcand;
    logic [MGW-1:0]  r_mplier;
    logic [DW-1:0]   r_den;
    logic [NW-1:0]   r_num;
    logic [DVW-1:0]  r_dvd;
    logic [DW-1:0]   r_rem;
    logic [QTW-1:0]  r_quo;
    logic [RW:0]     r_srem;
    logic [RW-1:0]   r_root;
    logic [CW-1:0]   r_count;
    logic [MGW-1:0]  r_mag;
    logic [QW-1:0]   r_sq;
    logic            r_ovf;

    logic [SW-1:0]   sum_abs;
    logic [NW-1:0]   alu_a;
    logic [NW-1:0]   alu_b;
    logic            alu_sub;
    logic [AW-1:0]   alu_res;
    logic            alu_ge;
    logic [NW-1:0]   acc_step;
    logic [DW:0]     div_a;
    logic [RW+2:0]   root_a;
    logic [RW+1:0]   root_b;
    logic            last_step;

    assign sum_abs = i_sum[SW-1] ? (~i_sum + 1'b1) : i_sum;

    assign div_a  = {r_rem, r_dvd[DVW-1]};
    assign root_a = {r_srem, r_quo[QTW-1 -: 2]};
    assign root_b = {r_root, 2'b01};

    // shared unit: add, or subtract with the borrow as the compare result
    assign alu_res  = {1'b0, alu_a} + ({1'b0, alu_b} ^ {AW{alu_sub}}) + AW'(alu_sub);
    assign alu_ge   = !alu_res[NW];
    assign acc_step = r_mplier[0] ? alu_res[NW-1:0] : r_acc;
    assign last_step = (r_cnt == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ssd_pkg::ST_IDLE: begin
                if (i_ctl.start) begin
                    n_state = (i_count < CW'(2)) ? ssd_pkg::ST_HOLD : ssd_pkg::ST_DEN;
                end
            end
            ssd_pkg::ST_DEN:  if (last_step) n_state = ssd_pkg::ST_MSQ;
            ssd_pkg::ST_MSQ:  if (last_step) n_state = ssd_pkg::ST_MAG;
            ssd_pkg::ST_MAG:  if (last_step) n_state = ssd_pkg::ST_SUB;
            ssd_pkg::ST_SUB:  n_state = ssd_pkg::ST_DIV;
            ssd_pkg::ST_DIV:  if (last_step) n_state = ssd_pkg::ST_ROOT;
            ssd_pkg::ST_ROOT: if (last_step) n_state = ssd_pkg::ST_HOLD;
            ssd_pkg::ST_HOLD: if (i_ctl.take) n_state = ssd_pkg::ST_IDLE;
            default:          n_state = ssd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            ssd_pkg::ST_DEN, ssd_pkg::ST_MSQ, ssd_pkg::ST_MAG: begin
                alu_a = r_acc;
                alu_b = r_mcand;
            end
            ssd_pkg::ST_SUB: begin
                alu_a   = r_num;
                alu_b   = r_acc;
                alu_sub = 1'b1;
            end
            ssd_pkg::ST_DIV: begin
                alu_a   = NW'(div_a);
                alu_b   = NW'(r_den);
                alu_sub = 1'b1;
            end
            ssd_pkg::ST_ROOT: begin
                alu_a   = NW'(root_a);
                alu_b   = NW'(root_b);
                alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ssd_pkg::ST_IDLE: begin
                if (i_ctl.start) begin
                    r_count  <= i_count;
                    r_mag    <= sum_abs[MGW-1:0];
                    r_sq     <= i_sq_sum;
                    r_ovf    <= i_ctl.overflow;
                    r_root   <= '0;
                    // n * (n - 1) first
                    r_acc    <= '0;
                    r_mcand  <= NW'(i_count);
                    r_mplier <= MGW'(i_count - CW'(1));
                    r_cnt    <= CNTW'(CW - 1);
                end
            end
            ssd_pkg::ST_DEN: begin
                if (last_step) begin
                    r_den    <= acc_step[DW-1:0];
                    r_acc    <= '0;
                    r_mcand  <= NW'(r_sq);
                    r_mplier <= MGW'(r_count);
                    r_cnt    <= CNTW'(CW - 1);
                end else begin
                    r_acc    <= acc_step;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - 1'b1;
                end
            end
            ssd_pkg::ST_MSQ: begin
                if (last_step) begin
                    r_num    <= acc_step;
                    r_acc    <= '0;
                    r_mcand  <= NW'(r_mag);
                    r_mplier <= r_mag;
                    r_cnt    <= CNTW'(MGW - 1);
                end else begin
                    r_acc    <= acc_step;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - 1'b1;
                end
            end
            ssd_pkg::ST_MAG: begin
                r_acc    <= acc_step;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt - 1'b1;
            end
            ssd_pkg::ST_SUB: begin
                r_dvd <= {alu_res[NW-1:0], ssd_pkg::FRAC_W'(0)};
                r_rem <= '0;
                r_cnt <= CNTW'(DVW - 1);
            end
            ssd_pkg::ST_DIV: begin
                r_rem <= alu_ge ? alu_res[DW-1:0] : div_a[DW-1:0];
                r_dvd <= r_dvd << 1;
                r_quo <= {r_quo[QTW-2:0], alu_ge};
                if (last_step) begin
                    r_srem <= '0;
                    r_root <= '0;
                    r_cnt  <= CNTW'(RW - 1);
                end else begin
                    r_cnt  <= r_cnt - 1'b1;
                end
            end
            ssd_pkg::ST_ROOT: begin
                r_srem <= alu_ge ? alu_res[RW:0] : root_a[RW:0];
                r_quo  <= r_quo << 2;
                r_root <= {r_root[RW-2:0], alu_ge};
                r_cnt  <= r_cnt - 1'b1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_sts.busy = (r_state != ssd_pkg::ST_IDLE);
    assign o_sts.done = (r_state == ssd_pkg::ST_HOLD);

    assign o_result.rms_noise  = r_root;
    assign o_result.overflowed = r_ovf;

endmodule

FILE: design/sample_std_deviation_top.sv
// ----------------------------------------------------------------------------
// Sample standard deviation
// Accumulates a block of signed samples and returns floor(256 * standard
// deviation) with an overflow flag on the last sample of the block.
// ----------------------------------------------------------------------------
//  channel | ports                               | payload
//  --------+-------------------------------------+----------------------------
//  input   | i_in_valid / o_in_ready             | i_in_item  (sample, last)
//  output  | o_out_valid / i_out_ready           | o_out_item (rms, overflow)
//
//  A sample that does not end the block is taken back to back.
//  The last sample starts the calculator, which forms the shift-add products,
//  the restoring division and the root through one add/subtract unit and
//  then holds the result.
//  A block of fewer than two samples skips straight to the result.
//  o_in_ready stays low until the result has moved to the output register;
//  a stalled output holds that result and the next block may then load.
//  Synchronous active-low reset clears the sums, the count and the output valid flag.
// ----------------------------------------------------------------------------
module sample_std_deviation_top #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ssd_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ssd_pkg::t_out_item  o_out_item
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = CW + 16;
    localparam int QW = CW + 30;

    logic [CW-1:0]        r_count;
    logic signed [SW-1:0] r_sum;
    logic [QW-1:0]        r_sq;
    logic                 r_ovf;
    logic                 r_out_valid;
    ssd_pkg::t_out_item   r_out_item;

    logic                 in_acc;
    logic                 room;
    logic signed [31:0]   sample_sq;
    logic [CW-1:0]        tot_count;
    logic signed [SW-1:0] tot_sum;
    logic [QW-1:0]        tot_sq;
    logic                 tot_ovf;

    ssd_pkg::t_calc_ctl   calc_ctl;
    ssd_pkg::t_calc_sts   calc_sts;
    ssd_pkg::t_out_item   calc_result;

    assign o_in_ready = !calc_sts.busy;
    assign in_acc     = i_in_valid && o_in_ready;

    // drop samples once the block is full
    assign room      = (r_count < CW'(MAX_SAMPLES));
    assign sample_sq = i_in_item.sample * i_in_item.sample;
    assign tot_count = room ? r_count + 1'b1 : r_count;
    assign tot_sum   = room ? r_sum + SW'(i_in_item.sample) : r_sum;
    assign tot_sq    = room ? r_sq + QW'(sample_sq[30:0]) : r_sq;
    assign tot_ovf   = r_ovf | !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            r_ovf   <= 1'b0;
        end else if (in_acc) begin
            if (i_in_item.last_sample) begin
                r_count <= '0;
                r_sum   <= '0;
                r_sq    <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_count <= tot_count;
                r_sum   <= tot_sum;
                r_sq    <= tot_sq;
                r_ovf   <= tot_ovf;
            end
        end
    end

    assign calc_ctl.start    = in_acc && i_in_item.last_sample;
    assign calc_ctl.overflow = tot_ovf;
    assign calc_ctl.take     = !r_out_valid || i_out_ready;

    ssd_calc #(
        .CW (CW)
    ) u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (calc_ctl),
        .i_count  (tot_count),
        .i_sum    (tot_sum),
        .i_sq_sum (tot_sq),
        .o_sts    (calc_sts),
        .o_result (calc_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (calc_sts.done && calc_ctl.take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (calc_sts.done && calc_ctl.take) begin
            r_out_item <= calc_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: design/ssd_check.sv
// ----------------------------------------------------------------------------
// Sample standard deviation port checker
// Watches the top level's handshakes and how the block paces items.
// ----------------------------------------------------------------------------
`include "sample_std_deviation_top_macros.svh"

module ssd_check (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input ssd_pkg::t_in_item   i_in_item,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input ssd_pkg::t_out_item  i_out_item
);

    // a stalled result holds
    `SSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_item), "stalled result item changed")

    // a sample inside the block never stalls the next one
    `SSD_ASSERT_NEXT(a_mid_ready, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_in_item.last_sample, i_in_ready, "ready dropped inside a block")

    // the last sample of a block starts the calculation
    `SSD_ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_item.last_sample, !i_in_ready, "ready held after the last item")

    // a result appears only out of the calculation
    `SSD_ASSERT_NOW(a_out_src, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready), "result item without a calculation")

endmodule

bind sample_std_deviation_top ssd_check u_ssd_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);
